FILE: rtl/core/ocr_box_region_filter_top_defines.svh
// Assertion macros for the OCR box region filter.
// Included by every RTL file that carries assertions; compiles to nothing for synthesis.
`ifndef OCR_BOX_REGION_FILTER_TOP_DEFINES_SVH
`define OCR_BOX_REGION_FILTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define OBRF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ocr_brf assertion failed");
// Checked at every edge, reset included.
`define OBRF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("ocr_brf assertion failed");
`else
`define OBRF_ASSERT(lbl, prop)
`define OBRF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/core/ocr_brf_pkg.sv
// Shared types and constants of the OCR box region filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package ocr_brf_pkg;

    localparam int unsigned MAX_LETTERS = 1048576;
    localparam int unsigned COORD_BITS  = 16;
    localparam int unsigned LETTER_BITS = $clog2(MAX_LETTERS);
    localparam int unsigned END_BITS    = LETTER_BITS + 1;

    localparam int unsigned IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_DATA_BITS = ((LETTER_BITS + END_BITS + 7) / 8) * 8;
    localparam int unsigned IN_USER_BITS  = 3;
    localparam int unsigned CFG_IDX_BITS  = 3;

    // tuser bit positions on the input stream
    localparam int unsigned USER_SPATIAL  = 0;
    localparam int unsigned USER_WORD_END = 1;
    localparam int unsigned USER_DOC_START = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_LEFT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_TOP    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REGION_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INCL_BOUNDARY = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESOLUTION    = 3'd5;

    // resolution codes; the unused fourth code behaves as line mode
    localparam logic [1:0] RES_CHAR = 2'd0;
    localparam logic [1:0] RES_WORD = 2'd1;
    localparam logic [1:0] RES_LINE = 2'd2;

    typedef logic [COORD_BITS-1:0]  t_coord;
    typedef logic [LETTER_BITS-1:0] t_index;
    typedef logic [END_BITS-1:0]    t_end;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_box;

    typedef struct packed {
        t_box       region;
        logic       include_boundary;
        logic [1:0] resolution;
    } t_cfg;

    typedef struct packed {
        t_box box;
        logic is_spatial;
        logic word_end;
        logic line_end;
        logic doc_start;
    } t_item;

    typedef struct packed {
        logic   emit;
        t_index first;
        t_end   end_idx;
        t_box   box;
    } t_grp_res;

endpackage

`default_nettype wire

FILE: rtl/core/ocr_brf_cfg.sv
// Configuration register file of the OCR box region filter.
// Depends on ocr_brf_pkg.
`default_nettype none

module ocr_brf_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_wr_en,
    input  wire logic [ocr_brf_pkg::CFG_IDX_BITS-1:0] i_wr_index,
    input  wire logic [ocr_brf_pkg::COORD_BITS-1:0]   i_wr_data,
    output ocr_brf_pkg::t_cfg                         o_cfg
);
    import ocr_brf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.region.left      <= '0;
            r_cfg.region.top       <= '0;
            r_cfg.region.right     <= '1;
            r_cfg.region.bottom    <= '1;
            r_cfg.include_boundary <= 1'b1;
            r_cfg.resolution       <= RES_CHAR;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_REGION_LEFT:   r_cfg.region.left      <= i_wr_data;
                CFG_REGION_TOP:    r_cfg.region.top       <= i_wr_data;
                CFG_REGION_RIGHT:  r_cfg.region.right     <= i_wr_data;
                CFG_REGION_BOTTOM: r_cfg.region.bottom    <= i_wr_data;
                CFG_INCL_BOUNDARY: r_cfg.include_boundary <= i_wr_data[0];
                CFG_RESOLUTION:    r_cfg.resolution       <= i_wr_data[1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/core/ocr_brf_track.sv
// Letter numbering and group tracking: letter counter, open-group union box and start.
// Depends on ocr_brf_pkg and the assertion macro header.
`default_nettype none
`include "ocr_box_region_filter_top_defines.svh"

module ocr_brf_track (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ocr_brf_pkg::t_item i_item,
    input  wire logic               i_adv,
    input  wire logic [1:0]         i_resolution,
    output ocr_brf_pkg::t_grp_res   o_res
);
    import ocr_brf_pkg::*;

    localparam t_index LAST_INDEX = LETTER_BITS'(MAX_LETTERS - 1);

    t_index r_count, n_count;
    t_index r_start, n_start;
    logic   r_open,  n_open;
    t_box   r_gbox,  n_gbox;

    t_index   idx;
    logic     open_cur;
    logic     closes;
    t_box     merged;
    t_grp_res res;

    always_comb begin
        // document start clears the counter and drops any open group first
        idx      = i_item.doc_start ? '0 : r_count;
        open_cur = i_item.doc_start ? 1'b0 : r_open;
        closes   = (i_resolution == RES_WORD) ? i_item.word_end : i_item.line_end;

        if (open_cur) begin
            merged.left   = (i_item.box.left < r_gbox.left)     ? i_item.box.left   : r_gbox.left;
            merged.top    = (i_item.box.top < r_gbox.top)       ? i_item.box.top    : r_gbox.top;
            merged.right  = (i_item.box.right > r_gbox.right)   ? i_item.box.right  : r_gbox.right;
            merged.bottom = (i_item.box.bottom > r_gbox.bottom) ? i_item.box.bottom : r_gbox.bottom;
        end else begin
            merged = i_item.box;
        end

        n_count = (idx == LAST_INDEX) ? '0 : idx + 1'b1;
        n_start = r_start;
        n_open  = open_cur;
        n_gbox  = r_gbox;

        res.emit    = 1'b0;
        res.first   = idx;
        res.end_idx = {1'b0, idx} + 1'b1;
        res.box     = i_item.box;

        if (i_item.is_spatial) begin
            if (i_resolution == RES_CHAR) begin
                res.emit = 1'b1;
            end else begin
                n_gbox  = merged;
                n_start = open_cur ? r_start : idx;
                n_open  = !closes;
                res.emit  = closes;
                res.first = n_start;
                res.box   = merged;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_start <= '0;
            r_open  <= 1'b0;
        end else if (i_adv) begin
            r_count <= n_count;
            r_start <= n_start;
            r_open  <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_gbox <= n_gbox;
        end
    end

    assign o_res = res;

    `OBRF_ASSERT(a_doc_start_count, i_adv && i_item.doc_start |=> r_count == t_index'(1))
    `OBRF_ASSERT(a_char_range_one, i_adv && res.emit && i_resolution == RES_CHAR |-> res.end_idx == {1'b0, res.first} + 1'b1)
    `OBRF_ASSERT(a_close_clears_open, i_adv && res.emit && i_resolution != RES_CHAR |=> !r_open)

endmodule

`default_nettype wire

FILE: rtl/core/ocr_brf_hit.sv
// Region test: overlap, or full containment when boundary letters are excluded.
// Depends on ocr_brf_pkg.
`default_nettype none

module ocr_brf_hit (
    input  wire ocr_brf_pkg::t_box i_box,
    input  wire ocr_brf_pkg::t_cfg i_cfg,
    output logic                   o_hit
);
    import ocr_brf_pkg::*;

    logic apart;
    logic contained;

    always_comb begin
        apart     = (i_cfg.region.left >= i_box.right) || (i_cfg.region.top >= i_box.bottom) ||
                    (i_cfg.region.right <= i_box.left) || (i_cfg.region.bottom <= i_box.top);
        contained = (i_box.right <= i_cfg.region.right) && (i_box.left >= i_cfg.region.left) &&
                    (i_box.top >= i_cfg.region.top) && (i_box.bottom <= i_cfg.region.bottom);
        o_hit     = !apart && (i_cfg.include_boundary || contained);
    end

endmodule

`default_nettype wire

FILE: rtl/core/ocr_box_region_filter_top.sv
// OCR box region filter, top level: stream ports, input register, result register.
// Depends on ocr_brf_pkg, ocr_brf_cfg, ocr_brf_track, ocr_brf_hit and the macro header.
//
// Takes one OCR letter per clock while the output is not stalled, and numbers letters
// from 0 (doc_start restarts at 0). Each letter passes an input register and a result
// register; a new letter can be taken while the one before is in the input register.
// The group update (union box, counter) between them is combinational; a stalled
// output holds one result while one more letter waits in the input register. In
// character mode every spatial letter gives one result; in word or line mode a result is
// given when an end mark falls on a spatial letter. Non-spatial letters are counted only.
// The user must write configuration only while no letter is in flight (not enforced here).
`default_nettype none
`include "ocr_box_region_filter_top_defines.svh"

module ocr_box_region_filter_top (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // input letters
    input  wire logic                                    i_s_axis_tvalid,
    output logic                                         o_s_axis_tready,
    // box_left, box_top, box_right, box_bottom
    input  wire logic [ocr_brf_pkg::IN_DATA_BITS-1:0]    i_s_axis_tdata,
    // is_spatial, word_end, doc_start
    input  wire logic [ocr_brf_pkg::IN_USER_BITS-1:0]    i_s_axis_tuser,
    // line_end
    input  wire logic                                    i_s_axis_tlast,
    // results
    output logic                                         o_m_axis_tvalid,
    input  wire logic                                    i_m_axis_tready,
    // range_first, range_end, zero fill
    output logic [ocr_brf_pkg::OUT_DATA_BITS-1:0]        o_m_axis_tdata,
    // hit
    output logic                                         o_m_axis_tuser,
    // configuration writes
    input  wire logic                                    i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  wire logic [ocr_brf_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [ocr_brf_pkg::COORD_BITS-1:0]      i_cfg_data
);
    import ocr_brf_pkg::*;

    localparam int unsigned PAD_BITS = OUT_DATA_BITS - LETTER_BITS - END_BITS;

    t_cfg     cfg;
    t_item    in_item;
    t_grp_res grp;
    logic     grp_hit;

    logic   r_in_valid, n_in_valid;
    t_item  r_in_item;
    logic   r_out_valid, n_out_valid;
    t_index r_out_first;
    t_end   r_out_end;
    logic   r_out_hit;

    logic out_free;
    logic adv;
    logic in_acc;

    assign o_cfg_ready = 1'b1;

    ocr_brf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    always_comb begin
        in_item.box.left   = i_s_axis_tdata[0*COORD_BITS +: COORD_BITS];
        in_item.box.top    = i_s_axis_tdata[1*COORD_BITS +: COORD_BITS];
        in_item.box.right  = i_s_axis_tdata[2*COORD_BITS +: COORD_BITS];
        in_item.box.bottom = i_s_axis_tdata[3*COORD_BITS +: COORD_BITS];
        in_item.is_spatial = i_s_axis_tuser[USER_SPATIAL];
        in_item.word_end   = i_s_axis_tuser[USER_WORD_END];
        in_item.line_end   = i_s_axis_tlast;
        in_item.doc_start  = i_s_axis_tuser[USER_DOC_START];
    end

    // advance the held item whenever the result slot is free or draining
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign adv             = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_acc) begin
            n_in_valid = 1'b1;
        end else if (adv) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (adv) begin
            n_out_valid = grp.emit;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_item <= in_item;
        end
        if (adv && grp.emit) begin
            r_out_first <= grp.first;
            r_out_end   <= grp.end_idx;
            r_out_hit   <= grp_hit;
        end
    end

    ocr_brf_track u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (r_in_item),
        .i_adv        (adv),
        .i_resolution (cfg.resolution),
        .o_res        (grp)
    );

    ocr_brf_hit u_hit (
        .i_box (grp.box),
        .i_cfg (cfg),
        .o_hit (grp_hit)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PAD_BITS{1'b0}}, r_out_end, r_out_first};
    assign o_m_axis_tuser  = r_out_hit;

    `OBRF_ASSERT_ALWAYS(a_stall_means_held, !o_s_axis_tready |-> r_in_valid && r_out_valid)
    `OBRF_ASSERT(a_accept_loads_stage, in_acc |=> r_in_valid)
    `OBRF_ASSERT(a_result_from_item, $rose(r_out_valid) |-> $past(r_in_valid))
    `OBRF_ASSERT(a_result_held_on_stall, r_out_valid && !i_m_axis_tready |=> r_out_valid && $stable(r_out_first))

endmodule

`default_nettype wire

FILE: verif/ocr_box_region_filter_top_tb.sv
// Self-checking testbench for ocr_box_region_filter_top: letters in, index ranges with hit out.
// Depends on ocr_brf_pkg and the RTL top; a scoreboard class predicts each range and hit flag.
`default_nettype none

module ocr_box_region_filter_top_tb;
    import ocr_brf_pkg::*;

    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASES        = 8;
    localparam int PHASE_LETTERS = 141;
    localparam int MAX_REPORTS   = 200;

    // indexes past the register list, written to check they are ignored
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;
    // fourth resolution code, decoded as line mode
    localparam logic [1:0] RES_LINE_ALIAS = 2'd3;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic [IN_DATA_BITS-1:0]  i_s_axis_tdata = '0;
    logic [IN_USER_BITS-1:0]  i_s_axis_tuser = '0;
    logic                     i_s_axis_tlast = 1'b0;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] o_m_axis_tdata;
    logic                     o_m_axis_tuser;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = CFG_REGION_LEFT;
    logic [COORD_BITS-1:0]    i_cfg_data = '0;

    bit quiet = 1'b0;
    int stall_left = 0;

    ocr_box_region_filter_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    class range_scoreboard;
        typedef struct {
            t_index first;
            t_end   end_idx;
            logic   hit;
        } t_range;

        t_range     pending_ranges[$];
        t_box       region;
        logic       incl_boundary;
        logic [1:0] resolution;
        t_index     letter_idx;
        t_box       group_box;
        t_index     group_first;
        bit         group_open;
        int         errors;

        function new();
            region.left   = '0;
            region.top    = '0;
            region.right  = '1;
            region.bottom = '1;
            incl_boundary = 1'b1;
            resolution    = RES_CHAR;
            letter_idx    = '0;
            group_box     = '0;
            group_first   = '0;
            group_open    = 1'b0;
            errors        = 0;
        endfunction

        function bit region_selects(t_box b);
            if (region.left >= b.right || region.top >= b.bottom ||
                region.right <= b.left || region.bottom <= b.top)
                return 1'b0;
            if (incl_boundary)
                return 1'b1;
            return (b.right <= region.right) && (b.left >= region.left) &&
                   (b.top >= region.top) && (b.bottom <= region.bottom);
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, t_coord data);
            case (idx)
                CFG_REGION_LEFT:   region.left   = data;
                CFG_REGION_TOP:    region.top    = data;
                CFG_REGION_RIGHT:  region.right  = data;
                CFG_REGION_BOTTOM: region.bottom = data;
                CFG_INCL_BOUNDARY: incl_boundary = data[0];
                CFG_RESOLUTION:    resolution    = data[1:0];
                default: ;
            endcase
        endfunction

        function void note_letter(t_item it);
            t_index idx;
            t_range r;
            bit     closes;
            if (it.doc_start) begin
                letter_idx = '0;
                group_open = 1'b0;
            end
            idx = letter_idx;
            letter_idx = (int'(letter_idx) + 1 >= MAX_LETTERS) ? '0 : letter_idx + 1'b1;
            if (!it.is_spatial)
                return;
            if (resolution == RES_CHAR) begin
                r.first   = idx;
                r.end_idx = t_end'(idx) + 1'b1;
                r.hit     = region_selects(it.box);
                pending_ranges = {pending_ranges, r};
                return;
            end
            closes = (resolution == RES_WORD) ? it.word_end : it.line_end;
            if (!group_open) begin
                group_first = idx;
                group_box   = it.box;
                group_open  = 1'b1;
            end else begin
                if (it.box.left < group_box.left)     group_box.left   = it.box.left;
                if (it.box.top < group_box.top)       group_box.top    = it.box.top;
                if (it.box.right > group_box.right)   group_box.right  = it.box.right;
                if (it.box.bottom > group_box.bottom) group_box.bottom = it.box.bottom;
            end
            if (closes) begin
                r.first    = group_first;
                r.end_idx  = t_end'(idx) + 1'b1;
                r.hit      = region_selects(group_box);
                group_open = 1'b0;
                pending_ranges = {pending_ranges, r};
            end
        endfunction

        function void check_range(t_index first, t_end end_idx, logic hit);
            t_range r;
            if (pending_ranges.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t unexpected result: expected none, actual first %0d end %0d hit %0b",
                             $time, first, end_idx, hit);
                return;
            end
            r = pending_ranges.pop_front();
            if (first !== r.first) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t range_first mismatch: expected %0d actual %0d",
                             $time, r.first, first);
            end
            if (end_idx !== r.end_idx) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t range_end mismatch: expected %0d actual %0d",
                             $time, r.end_idx, end_idx);
            end
            if (hit !== r.hit) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t hit mismatch: expected %0b actual %0b", $time, r.hit, hit);
            end
        endfunction
    endclass

    range_scoreboard board = new();

    always #5 i_clk = ~i_clk;

    // result side: check every accepted item, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_range(o_m_axis_tdata[LETTER_BITS-1:0],
                              o_m_axis_tdata[LETTER_BITS +: END_BITS], o_m_axis_tuser);
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (quiet) begin
            stall_left = 0;
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    function automatic int idle_gap();
        if (quiet || $urandom_range(0, 4) != 0)
            return 0;
        return $urandom_range(1, 15);
    endfunction

    function automatic t_item letter(int l, int t, int r, int b, bit sp, bit we, bit le, bit ds);
        t_item it;
        it.box.left   = t_coord'(l);
        it.box.top    = t_coord'(t);
        it.box.right  = t_coord'(r);
        it.box.bottom = t_coord'(b);
        it.is_spatial = sp;
        it.word_end   = we;
        it.line_end   = le;
        it.doc_start  = ds;
        return it;
    endfunction

    // coordinate a little around the span between a and b
    function automatic t_coord near_coord(t_coord a, t_coord b);
        int lo;
        int hi;
        lo = ((a < b) ? int'(a) : int'(b)) - 64;
        hi = ((a < b) ? int'(b) : int'(a)) + 64;
        if (lo < 0) lo = 0;
        if (hi > 65535) hi = 65535;
        return t_coord'($urandom_range(hi, lo));
    endfunction

    function automatic t_coord grow(t_coord c);
        int v;
        v = int'(c) + $urandom_range(0, 48);
        return (v > 65535) ? t_coord'(65535) : t_coord'(v);
    endfunction

    function automatic t_box random_box();
        t_box b;
        if ($urandom_range(0, 4) == 0) begin
            b.left   = t_coord'($urandom);
            b.top    = t_coord'($urandom);
            b.right  = t_coord'($urandom);
            b.bottom = t_coord'($urandom);
        end else begin
            b.left   = near_coord(board.region.left, board.region.right);
            b.top    = near_coord(board.region.top, board.region.bottom);
            b.right  = grow(b.left);
            b.bottom = grow(b.top);
        end
        return b;
    endfunction

    task automatic send_letter(t_item it, int gap);
        logic [IN_USER_BITS-1:0] user;
        user = '0;
        user[USER_SPATIAL]   = it.is_spatial;
        user[USER_WORD_END]  = it.word_end;
        user[USER_DOC_START] = it.doc_start;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {it.box.bottom, it.box.right, it.box.top, it.box.left};
        i_s_axis_tuser  <= user;
        i_s_axis_tlast  <= it.line_end;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_letter(it);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold input until every expected range is out, then let the pipe empty
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending_ranges.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, t_coord data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_region(int l, int t, int r, int b);
        write_reg(CFG_REGION_LEFT, t_coord'(l));
        write_reg(CFG_REGION_TOP, t_coord'(t));
        write_reg(CFG_REGION_RIGHT, t_coord'(r));
        write_reg(CFG_REGION_BOTTOM, t_coord'(b));
    endtask

    task automatic write_modes(logic incl, logic [1:0] res);
        t_coord d;
        d = t_coord'($urandom);
        d[0] = incl;
        write_reg(CFG_INCL_BOUNDARY, d);
        d = t_coord'($urandom);
        d[1:0] = res;
        write_reg(CFG_RESOLUTION, d);
    endtask

    task automatic phase_config(int ph);
        int l;
        int t;
        int w;
        int h;
        if (ph == 0) begin
            write_region(0, 0, 65535, 65535);
        end else if (ph == 5) begin
            write_region(65535, 65535, 0, 0);
        end else begin
            l = $urandom_range(0, 65535);
            t = $urandom_range(0, 65535);
            w = l + $urandom_range(0, 8000);
            h = t + $urandom_range(0, 8000);
            if (w > 65535) w = 65535;
            if (h > 65535) h = 65535;
            if (ph == 6)
                write_region(w, h, l, t);
            else
                write_region(l, t, w, h);
        end
        write_modes(((ph + ph / 4) % 2) != 0, 2'(ph % 4));
    endtask

    // words of one to six letters, mostly spatial, with some broken end marks
    task automatic run_phase(int ph, int count);
        int    sent;
        int    wlen;
        t_item it;
        sent = 0;
        while (sent < count) begin
            wlen = $urandom_range(1, 6);
            for (int j = 0; j < wlen && sent < count; j++) begin
                it.box        = random_box();
                it.is_spatial = ($urandom_range(0, 9) != 0);
                it.word_end   = (j == wlen - 1);
                it.line_end   = it.word_end && ($urandom_range(0, 2) == 0);
                if ($urandom_range(0, 9) == 0) begin
                    it.word_end = $urandom_range(0, 1);
                    it.line_end = $urandom_range(0, 1);
                end
                it.doc_start = (sent == 0) || ($urandom_range(0, 79) == 0);
                if (ph == 2 && sent == count / 2)
                    drain();
                send_letter(it, idle_gap());
                sent++;
            end
        end
    endtask

    initial begin
        #2_000_000;
        $display("** ocr_box_region_filter_top: FAILED **");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // character mode at reset values: degenerate, full-span and inverted boxes
        send_letter(letter(0, 0, 0, 0, 1, 0, 0, 1), idle_gap());
        send_letter(letter(0, 0, 65535, 65535, 1, 0, 0, 0), idle_gap());
        send_letter(letter(65535, 65535, 65535, 65535, 1, 1, 1, 0), idle_gap());
        send_letter(letter(10, 20, 30, 40, 0, 1, 1, 0), idle_gap());
        send_letter(letter(200, 300, 100, 150, 1, 0, 0, 0), idle_gap());
        drain();

        // word mode with containment
        write_region(100, 100, 200, 200);
        write_reg(CFG_INCL_BOUNDARY, 16'h0002);
        write_reg(CFG_RESOLUTION, {14'h3FFF, RES_WORD});
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0000);
        send_letter(letter(120, 120, 130, 130, 1, 0, 0, 0), idle_gap());
        send_letter(letter(0, 0, 65535, 65535, 0, 1, 1, 0), idle_gap());
        send_letter(letter(150, 110, 190, 199, 1, 1, 0, 0), idle_gap());
        send_letter(letter(90, 120, 110, 130, 1, 1, 0, 0), idle_gap());
        send_letter(letter(200, 120, 250, 130, 1, 1, 0, 0), idle_gap());
        // document start drops the open word
        send_letter(letter(120, 120, 130, 130, 1, 0, 0, 0), idle_gap());
        send_letter(letter(140, 140, 150, 150, 1, 1, 0, 1), idle_gap());
        drain();

        // line mode, then the fourth code
        write_modes(1'b1, RES_LINE);
        send_letter(letter(110, 110, 120, 120, 1, 1, 0, 0), idle_gap());
        send_letter(letter(190, 190, 260, 260, 1, 0, 1, 0), idle_gap());
        send_letter(letter(300, 300, 400, 400, 1, 1, 1, 0), idle_gap());
        drain();
        write_reg(CFG_RESOLUTION, {14'h0, RES_LINE_ALIAS});
        send_letter(letter(150, 150, 160, 160, 1, 1, 0, 0), idle_gap());
        send_letter(letter(170, 170, 180, 180, 1, 0, 1, 0), idle_gap());
        // leave a group open across a switch to character mode and back
        send_letter(letter(105, 105, 115, 115, 1, 0, 0, 0), idle_gap());
        drain();
        write_reg(CFG_RESOLUTION, {14'h0, RES_CHAR});
        send_letter(letter(130, 130, 140, 140, 1, 1, 1, 0), idle_gap());
        drain();
        write_reg(CFG_RESOLUTION, {14'h0, RES_WORD});
        send_letter(letter(180, 180, 199, 199, 1, 1, 0, 0), idle_gap());
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == PHASES - 1)
                quiet = 1'b1;
            phase_config(ph);
            run_phase(ph, PHASE_LETTERS);
            drain();
        end

        if (board.pending_ranges.size() != 0)
            $display("%0t %0d expected results never arrived", $time,
                     board.pending_ranges.size());
        if (board.errors == 0 && board.pending_ranges.size() == 0) begin
            $display("** ocr_box_region_filter_top: PASSED **");
        end else begin
            $display("** ocr_box_region_filter_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/ocr_brf_pkg.sv
rtl/core/ocr_brf_cfg.sv
rtl/core/ocr_brf_track.sv
rtl/core/ocr_brf_hit.sv
rtl/core/ocr_box_region_filter_top.sv
verif/ocr_box_region_filter_top_tb.sv
